// File: src/sppf_pkg.sv
// shared types, constants and helper functions for the serial pnp id frame finder
// no dependencies; used by sppf_ctrl, sppf_dp and the top level
`default_nettype none

package sppf_pkg;

  localparam int BufBytes = 256;
  localparam int AddrW    = $clog2(BufBytes);
  localparam int CntW     = AddrW + 1;

  localparam int FrameMinLen = 11;
  localparam int IdFirst     = 3;
  localparam int AlphaEnd    = 6;
  localparam int IdEnd       = 10;

  localparam logic [7:0] MarkBegin6 = 8'h08;
  localparam logic [7:0] MarkBegin7 = 8'h28;
  localparam logic [7:0] MarkEnd6   = 8'h09;
  localparam logic [7:0] MarkEnd7   = 8'h29;
  localparam logic [7:0] MarkExt6   = 8'h3c;
  localparam logic [7:0] MarkExt7   = 8'h5c;
  localparam logic [7:0] SixOffset  = 8'h20;
  localparam logic [7:0] RevMask    = 8'hc0;

  localparam logic [2:0] KindHeader = 3'd0;
  localparam logic [2:0] KindUser   = 3'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_CHECK,
    ST_EMIT_SEL,
    ST_EMIT_WAIT
  } state_e;

  typedef enum logic [2:0] {
    PH_BEGIN,
    PH_REV,
    PH_ID,
    PH_K10,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    logic store;
    logic scan_init;
    logic k_next;
    logic ofs_next;
    logic take_begin;
    logic take_rev;
    logic take_id;
    logic take_mark;
    logic set_found;
    logic scan_end_nf;
    logic emit_load;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    phase_e phase;
    logic   hit_begin;
    logic   too_short;
    logic   rev_ok;
    logic   id_ok;
    logic   is_end;
    logic   is_ext;
    logic   at_end;
    logic   ofs_end;
    logic   item_here;
    logic   out_taken;
    logic   out_last;
  } sts_t;

  // letters or underscore for the first three id characters, hex digits after
  function automatic logic id_char_ok(input logic alpha, input logic [7:0] c);
    logic up, dig, hex;
    up  = (c >= 8'h41) && (c <= 8'h5a);
    dig = (c >= 8'h30) && (c <= 8'h39);
    hex = (c >= 8'h41) && (c <= 8'h46);
    return alpha ? (up || (c == 8'h5f)) : (dig || hex);
  endfunction

endpackage

`default_nettype wire

// File: src/sppf_ctrl.sv
// controller state machine of the serial pnp id frame finder
// depends on sppf_pkg; drives command struct to sppf_dp, reads its status struct
`default_nettype none

module sppf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          last_byte_i,
  output logic               in_ready_o,
  input  wire sppf_pkg::sts_t sts_i,
  output sppf_pkg::cmd_t     cmd_o
);

  sppf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sppf_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    logic fail;
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    fail       = 1'b0;
    unique case (state_q)
      sppf_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store = 1'b1;
          if (last_byte_i) begin
            cmd_o.scan_init = 1'b1;
            state_d         = sppf_pkg::ST_FETCH;
          end
        end
      end
      sppf_pkg::ST_FETCH: begin
        state_d = sppf_pkg::ST_CHECK;
      end
      sppf_pkg::ST_CHECK: begin
        state_d = sppf_pkg::ST_FETCH;
        unique case (sts_i.phase)
          sppf_pkg::PH_BEGIN: begin
            if (sts_i.hit_begin && !sts_i.too_short) begin
              cmd_o.take_begin = 1'b1;
              cmd_o.k_next     = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          sppf_pkg::PH_REV: begin
            if (sts_i.rev_ok) begin
              cmd_o.take_rev = 1'b1;
              cmd_o.k_next   = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          sppf_pkg::PH_ID: begin
            if (sts_i.id_ok) begin
              cmd_o.take_id = 1'b1;
              cmd_o.k_next  = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          sppf_pkg::PH_K10: begin
            if (sts_i.is_end) begin
              cmd_o.set_found = 1'b1;
              state_d         = sppf_pkg::ST_EMIT_SEL;
            end else if (sts_i.is_ext && !sts_i.at_end) begin
              cmd_o.take_mark = 1'b1;
              cmd_o.k_next    = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end
          sppf_pkg::PH_TAIL: begin
            priority if (sts_i.is_end) begin
              cmd_o.take_mark = 1'b1;
              cmd_o.set_found = 1'b1;
              state_d         = sppf_pkg::ST_EMIT_SEL;
            end else if (sts_i.at_end) begin
              fail = 1'b1;
            end else begin
              cmd_o.take_mark = sts_i.is_ext;
              cmd_o.k_next    = 1'b1;
            end
          end
          default: fail = 1'b1;
        endcase
        if (fail) begin
          if (sts_i.ofs_end) begin
            cmd_o.scan_end_nf = 1'b1;
            state_d           = sppf_pkg::ST_EMIT_SEL;
          end else begin
            cmd_o.ofs_next = 1'b1;
          end
        end
      end
      sppf_pkg::ST_EMIT_SEL: begin
        if (sts_i.item_here) begin
          cmd_o.emit_load = 1'b1;
          state_d         = sppf_pkg::ST_EMIT_WAIT;
        end else begin
          cmd_o.emit_next = 1'b1;
        end
      end
      sppf_pkg::ST_EMIT_WAIT: begin
        if (sts_i.out_taken) begin
          if (sts_i.out_last) begin
            state_d = sppf_pkg::ST_LOAD;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = sppf_pkg::ST_EMIT_SEL;
          end
        end
      end
      default: state_d = sppf_pkg::ST_LOAD;
    endcase
  end

endmodule

`default_nettype wire

// File: src/sppf_dp.sv
// datapath of the serial pnp id frame finder: reply buffer, scan registers, output register
// depends on sppf_pkg; commanded by sppf_ctrl
`default_nettype none

module sppf_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     data_byte_i,
  input  wire sppf_pkg::cmd_t cmd_i,
  output sppf_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [2:0]          item_kind_o,
  output logic                frame_found_o,
  output logic [7:0]          start_offset_o,
  output logic [8:0]          span_length_o,
  output logic                six_bit_form_o,
  output logic [11:0]         pnp_revision_o,
  output logic [55:0]         eisa_id_chars_o,
  output logic                last_item_o
);

  localparam int AW = sppf_pkg::AddrW;
  localparam int CW = sppf_pkg::CntW;

  logic [7:0] mem [sppf_pkg::BufBytes];
  logic [7:0] rd_q;

  logic [CW-1:0] fill_q, k_q;
  logic [AW-1:0] ofs_q;
  logic [2:0]    n_q, j_q;
  logic          open_q, found_q, out_valid_q;
  logic [3:0]    present_q;
  logic          six_q;
  logic [11:0]   rev_q;
  logic [55:0]   id_q;
  logic [CW-1:0] span_q;
  logic [AW-1:0] start_q [4];
  logic [CW-1:0] flen_q  [4];

  logic [AW-1:0] addr;
  logic [CW-1:0] avail;
  logic [7:0]    id_c;
  logic          full;
  logic [1:0]    close_idx, new_idx, fsel;
  logic          out_last;
  logic [CW-1:0] flen_sel;

  assign addr      = ofs_q + k_q[AW-1:0];
  assign avail     = fill_q - {1'b0, ofs_q};
  assign id_c      = rd_q + (six_q ? sppf_pkg::SixOffset : 8'h00);
  assign full      = (fill_q >= CW'(sppf_pkg::BufBytes));
  assign close_idx = 2'(n_q - 3'd1);
  assign new_idx   = n_q[1:0];
  assign fsel      = 2'(j_q - 3'd1);
  assign out_last  = !found_q || ((present_q >> j_q) == 4'd0);

  always_comb begin
    flen_sel = flen_q[fsel];
    if (j_q == sppf_pkg::KindUser && flen_sel >= CW'(2)) begin
      flen_sel = flen_sel - CW'(2);
    end
  end

  always_comb begin
    sts_o = '0;
    priority if (k_q == '0) begin
      sts_o.phase = sppf_pkg::PH_BEGIN;
    end else if (k_q < CW'(sppf_pkg::IdFirst)) begin
      sts_o.phase = sppf_pkg::PH_REV;
    end else if (k_q < CW'(sppf_pkg::IdEnd)) begin
      sts_o.phase = sppf_pkg::PH_ID;
    end else if (k_q == CW'(sppf_pkg::IdEnd)) begin
      sts_o.phase = sppf_pkg::PH_K10;
    end else begin
      sts_o.phase = sppf_pkg::PH_TAIL;
    end
    sts_o.hit_begin = (rd_q == sppf_pkg::MarkBegin6) || (rd_q == sppf_pkg::MarkBegin7);
    sts_o.too_short = avail < CW'(sppf_pkg::FrameMinLen);
    sts_o.rev_ok    = (rd_q & sppf_pkg::RevMask) == 8'h00;
    sts_o.id_ok     = sppf_pkg::id_char_ok(k_q < CW'(sppf_pkg::AlphaEnd), id_c);
    sts_o.is_end    = rd_q == (six_q ? sppf_pkg::MarkEnd6 : sppf_pkg::MarkEnd7);
    sts_o.is_ext    = rd_q == (six_q ? sppf_pkg::MarkExt6 : sppf_pkg::MarkExt7);
    sts_o.at_end    = (k_q + CW'(1)) == avail;
    sts_o.ofs_end   = ({1'b0, ofs_q} + CW'(1)) >= fill_q;
    sts_o.item_here = (j_q == sppf_pkg::KindHeader) || present_q[fsel];
    sts_o.out_taken = out_valid_q && out_ready_i;
    sts_o.out_last  = last_item_o;
  end

  // buffer: one write port at the fill pointer, registered read at the scan address
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem[fill_q[AW-1:0]] <= data_byte_i;
    end
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      k_q         <= '0;
      ofs_q       <= '0;
      n_q         <= '0;
      j_q         <= '0;
      open_q      <= 1'b0;
      found_q     <= 1'b0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.store && !full) begin
        fill_q <= fill_q + CW'(1);
      end
      if (cmd_i.scan_init) begin
        ofs_q <= '0;
        k_q   <= '0;
      end
      if (cmd_i.k_next) begin
        k_q <= k_q + CW'(1);
      end
      if (cmd_i.ofs_next) begin
        ofs_q <= ofs_q + AW'(1);
        k_q   <= '0;
      end
      if (cmd_i.take_begin) begin
        present_q <= '0;
        n_q       <= '0;
        open_q    <= 1'b0;
      end
      if (cmd_i.take_mark) begin
        if (open_q) begin
          open_q <= 1'b0;
        end
        if (cmd_i.k_next && sts_o.is_ext && n_q < 3'd4) begin
          present_q[new_idx] <= 1'b1;
          open_q             <= 1'b1;
          n_q                <= n_q + 3'd1;
        end
      end
      if (cmd_i.set_found || cmd_i.scan_end_nf) begin
        found_q <= cmd_i.set_found;
        fill_q  <= '0;
        j_q     <= '0;
      end
      if (cmd_i.emit_next) begin
        j_q <= j_q + 3'd1;
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_begin) begin
      six_q <= (rd_q == sppf_pkg::MarkBegin6);
      rev_q <= '0;
      id_q  <= '0;
    end
    if (cmd_i.take_rev) begin
      rev_q <= {rev_q[5:0], rd_q[5:0]};
    end
    if (cmd_i.take_id) begin
      id_q <= {id_q[47:0], id_c};
    end
    if (cmd_i.take_mark) begin
      if (open_q) begin
        flen_q[close_idx] <= CW'(addr - start_q[close_idx]);
      end
      if (cmd_i.k_next && sts_o.is_ext && n_q < 3'd4) begin
        start_q[new_idx] <= addr + AW'(1);
      end
    end
    if (cmd_i.set_found) begin
      span_q <= k_q + CW'(1);
    end
    if (cmd_i.emit_load) begin
      last_item_o <= out_last;
      if (j_q == sppf_pkg::KindHeader) begin
        item_kind_o     <= sppf_pkg::KindHeader;
        frame_found_o   <= found_q;
        start_offset_o  <= found_q ? 8'(ofs_q) : 8'h00;
        span_length_o   <= found_q ? 9'(span_q) : 9'h000;
        six_bit_form_o  <= found_q && six_q;
        pnp_revision_o  <= found_q ? rev_q : 12'h000;
        eisa_id_chars_o <= found_q ? id_q : 56'h0;
      end else begin
        item_kind_o     <= j_q;
        frame_found_o   <= 1'b1;
        start_offset_o  <= 8'(start_q[fsel]);
        span_length_o   <= 9'(flen_sel);
        six_bit_form_o  <= six_q;
        pnp_revision_o  <= rev_q;
        eisa_id_chars_o <= id_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= 3'd4)
    else $error("field count beyond four");
  assert property (@(posedge clk_i) disable iff (!rst_ni) open_q |-> (n_q != 3'd0))
    else $error("open field with no field recorded");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CW'(sppf_pkg::BufBytes))
    else $error("fill count beyond buffer size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (present_q != 4'd0) |-> (n_q != 3'd0))
    else $error("field marked present with zero count");

endmodule

`default_nettype wire

// File: src/serial_pnp_id_frame_finder_top.sv
// top level of the serial pnp id frame finder
// depends on sppf_pkg, sppf_ctrl and sppf_dp
`default_nettype none

// Takes a modem reply one byte per beat into a 256-byte buffer (bytes past
// the end are dropped) and, after the beat flagged last_byte, scans it for a
// serial plug-and-play id frame. Loading accepts one beat per cycle.
// The scan shares one buffer read port and takes each byte examined
// through a read state and then a check state, trying offsets in order
// from 0; a candidate offset stops at the first byte that rules it out.
// Results then go out as a header beat and one beat per extended field
// present (serial, class, device id, user name); each beat passes through
// a select state and then waits for its output handshake, and each absent
// field skipped before a present one adds one more pass through the
// select state. last_item marks the final beat. Input is not taken while
// scanning or emitting. The buffer needs no clearing after reset: only
// entries below the fill count are read.
module serial_pnp_id_frame_finder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       item_kind_o,
  output logic             frame_found_o,
  output logic [7:0]       start_offset_o,
  output logic [8:0]       span_length_o,
  output logic             six_bit_form_o,
  output logic [11:0]      pnp_revision_o,
  output logic [55:0]      eisa_id_chars_o,
  output logic             last_item_o
);

  // command and status between the state machine and the datapath
  sppf_pkg::cmd_t cmd;
  sppf_pkg::sts_t sts;

  // sequencer: load, fetch/check per byte, then select/wait per result beat
  sppf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // buffer, frame registers, field table and output register
  sppf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (data_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .item_kind_o     (item_kind_o),
    .frame_found_o   (frame_found_o),
    .start_offset_o  (start_offset_o),
    .span_length_o   (span_length_o),
    .six_bit_form_o  (six_bit_form_o),
    .pnp_revision_o  (pnp_revision_o),
    .eisa_id_chars_o (eisa_id_chars_o),
    .last_item_o     (last_item_o)
  );

endmodule

`default_nettype wire
